// ----- design/ght_pkg.sv -----
`default_nettype none

package ght_pkg;

   // Operation codes carried in the request word.
   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_NEXT   = 2'd3
   } op_type;

   // Status codes returned in the response word.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_INVALID   = 3'd1,
      STATUS_DUPLICATE = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_NOT_FOUND = 3'd4,
      STATUS_END       = 3'd5
   } status_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LOOKUP,
      ST_DECIDE
   } state_type;

   localparam logic [6:0]  CAPACITY_RESET = 7'd64;
   localparam logic [31:0] GEN_MAX        = 32'hFFFF_FFFF;

   typedef struct packed {
      op_type      op;
      logic [31:0] connection_key;
      logic [9:0]  handle_index;
      logic [31:0] handle_generation;
      logic [10:0] cursor;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [9:0]  out_index;
      logic [31:0] out_generation;
      logic [31:0] out_key;
      logic [10:0] next_cursor;
      logic [10:0] entry_count;
   } rsp_type;

   // One slot of the table store.
   typedef struct packed {
      logic        occupied;
      logic [31:0] generation;
      logic [31:0] key;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic clear;
      logic issue;
      logic lookup;
      logic finish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type in_op;
      logic   in_key_zero;
      logic   clear_done;
      logic   scan_end;
      logic   rd_pending;
   } stat_type;

endpackage

`default_nettype wire

// ----- design/ght_ctrl.sv -----
`default_nettype none

module ght_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   input  ght_pkg::stat_type stat,
   output ght_pkg::cmd_type  cmd
);
   import ght_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and output-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (stat.in_op == OP_ADD && stat.in_key_zero) begin
                  state_in = ST_DECIDE;
               end else if (stat.in_op == OP_ADD || stat.in_op == OP_NEXT) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = !stat.scan_end;
            if (stat.scan_end && !stat.rd_pending) state_in = ST_DECIDE;
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            // The store is updated together with loading the output word.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- design/ght_datapath.sv -----
`default_nettype none

module ght_datapath #(
   parameter int SLOTS = 64
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               csr_write_enable,
   input  wire        [6:0]  csr_write_data,
   input  ght_pkg::req_type  req_data,
   output ght_pkg::rsp_type  rsp_data,
   input  ght_pkg::cmd_type  cmd,
   output ght_pkg::stat_type stat
);
   import ght_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   // Slot store with one write and one registered read port.
   entry_type mem [SLOTS];

   logic [6:0]    capacity_ff;
   req_type       req_ff;
   rsp_type       rsp_ff, rsp_in;
   logic [CW-1:0] addr_ff, addr_in;
   logic [CW-1:0] count_ff, count_in;
   entry_type     rd_word_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          scan_vld_ff;
   logic          dup_ff, dup_in;
   logic          got_ff, got_in;
   logic [IW-1:0] at_ff, at_in;
   logic [31:0]   at_gen_ff, at_gen_in;
   logic [31:0]   at_key_ff, at_key_in;

   logic [CW-1:0] cap_eff;
   logic [10:0]   cap_wide;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   entry_type     mem_wdata;
   logic          handle_ok;
   logic [31:0]   new_gen;

   function automatic logic [31:0] advance_gen(input logic [31:0] g);
      if (g == 32'd0 || g == GEN_MAX) return 32'd1;
      return g + 32'd1;
   endfunction

   // Effective capacity saturates at the built slot count.
   assign cap_eff  = ({25'd0, capacity_ff} > SLOTS) ? CW'(SLOTS) : CW'(capacity_ff);
   assign cap_wide = 11'(cap_eff);

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write_enable) begin
         capacity_ff <= csr_write_data;
      end
   end

   // Status back to the controller.
   assign stat.in_op       = req_data.op;
   assign stat.in_key_zero = (req_data.connection_key == 32'd0);
   assign stat.clear_done  = (addr_ff == CW'(SLOTS - 1));
   assign stat.scan_end    = (addr_ff >= cap_eff) || (req_ff.op == OP_NEXT && got_ff);
   assign stat.rd_pending  = scan_vld_ff;

   // Scan pointer: clearing sweep, scan start and scan step.
   always_comb begin
      addr_in = addr_ff;
      if (cmd.load) begin
         if (req_data.op == OP_NEXT) begin
            addr_in = (req_data.cursor >= cap_wide) ? cap_eff : CW'(req_data.cursor);
         end else begin
            addr_in = '0;
         end
      end else if (cmd.clear || cmd.issue) begin
         addr_in = addr_ff + CW'(1);
      end
   end

   // Read port.
   assign rd_en   = cmd.issue || cmd.lookup;
   assign rd_addr = cmd.lookup ? req_ff.handle_index[IW-1:0] : addr_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= mem[rd_addr];
         rd_idx_ff  <= rd_addr;
      end
   end

   // Scan evaluation: duplicate and first free slot for add, first occupied for next.
   always_comb begin
      dup_in    = dup_ff;
      got_in    = got_ff;
      at_in     = at_ff;
      at_gen_in = at_gen_ff;
      at_key_in = at_key_ff;
      if (cmd.load) begin
         dup_in = 1'b0;
         got_in = 1'b0;
      end else if (scan_vld_ff) begin
         if (req_ff.op == OP_ADD) begin
            if (rd_word_ff.occupied && rd_word_ff.key == req_ff.connection_key) begin
               dup_in = 1'b1;
            end
            if (!got_ff && !rd_word_ff.occupied) begin
               got_in    = 1'b1;
               at_in     = rd_idx_ff;
               at_gen_in = rd_word_ff.generation;
            end
         end else if (req_ff.op == OP_NEXT) begin
            if (!got_ff && rd_word_ff.occupied) begin
               got_in    = 1'b1;
               at_in     = rd_idx_ff;
               at_gen_in = rd_word_ff.generation;
               at_key_in = rd_word_ff.key;
            end
         end
      end
   end

   // Handle check for remove and find.
   assign handle_ok = (req_ff.handle_generation != 32'd0)
                   && ({1'b0, req_ff.handle_index} < cap_wide)
                   && rd_word_ff.occupied
                   && (rd_word_ff.generation == req_ff.handle_generation);

   assign new_gen = advance_gen(at_gen_ff);

   // Decision: response word, store write and count update.
   always_comb begin
      rsp_in    = '0;
      mem_we    = 1'b0;
      mem_waddr = addr_ff[IW-1:0];
      mem_wdata = '0;
      count_in  = count_ff;
      if (cmd.clear) begin
         mem_we = 1'b1;
      end else if (cmd.finish) begin
         case (req_ff.op)
            OP_ADD: begin
               if (req_ff.connection_key == 32'd0) begin
                  rsp_in.status = STATUS_INVALID;
               end else if (dup_ff) begin
                  rsp_in.status = STATUS_DUPLICATE;
               end else if (!got_ff) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  rsp_in.status         = STATUS_OK;
                  rsp_in.out_index      = 10'(at_ff);
                  rsp_in.out_generation = new_gen;
                  mem_we                = 1'b1;
                  mem_waddr             = at_ff;
                  mem_wdata.occupied    = 1'b1;
                  mem_wdata.generation  = new_gen;
                  mem_wdata.key         = req_ff.connection_key;
                  count_in              = count_ff + CW'(1);
               end
            end
            OP_REMOVE: begin
               if (handle_ok) begin
                  rsp_in.status        = STATUS_OK;
                  mem_we               = 1'b1;
                  mem_waddr            = req_ff.handle_index[IW-1:0];
                  mem_wdata.generation = rd_word_ff.generation;
                  if (count_ff != '0) count_in = count_ff - CW'(1);
               end else begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end
            end
            OP_FIND: begin
               if (handle_ok) begin
                  rsp_in.status  = STATUS_OK;
                  rsp_in.out_key = rd_word_ff.key;
               end else begin
                  rsp_in.status = STATUS_NOT_FOUND;
               end
            end
            OP_NEXT: begin
               if (got_ff) begin
                  rsp_in.status         = STATUS_OK;
                  rsp_in.out_index      = 10'(at_ff);
                  rsp_in.out_generation = at_gen_ff;
                  rsp_in.out_key        = at_key_ff;
                  rsp_in.next_cursor    = 11'(at_ff) + 11'd1;
               end else begin
                  rsp_in.status      = STATUS_END;
                  rsp_in.next_cursor = cap_wide;
               end
            end
            default: rsp_in.status = STATUS_NOT_FOUND;
         endcase
         rsp_in.entry_count = 11'(count_in);
      end
   end

   // Store write port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         count_ff    <= '0;
         scan_vld_ff <= 1'b0;
         dup_ff      <= 1'b0;
         got_ff      <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         count_ff    <= count_in;
         scan_vld_ff <= cmd.issue;
         dup_ff      <= dup_in;
         got_ff      <= got_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      at_ff     <= at_in;
      at_gen_ff <= at_gen_in;
      at_key_ff <= at_key_in;
      if (cmd.load) req_ff <= req_data;
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ----- design/generational_handle_table.sv -----
// Channel   Direction  Handshake              Word
// req_      in         req_valid/req_ready    ght_pkg::req_type
// rsp_      out        rsp_valid/rsp_ready    ght_pkg::rsp_type
// csr_      in         csr_write_enable       capacity, 7 bits
//
// Add and next walk the slot store one entry per cycle through its single
// read port; an add with a null key skips the walk, and remove and find
// read only the addressed slot. After reset a clearing sweep writes every
// slot before the first word is taken. One word is worked on at a time; the
// response sits in an output register, so a new word is taken while it
// waits to be read.
`default_nettype none

module generational_handle_table #(
   parameter int SLOTS = 64
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  ght_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_ready,
   output ght_pkg::rsp_type rsp_data,
   input  wire              csr_write_enable,
   input  wire       [6:0]  csr_write_data
);
   import ght_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencing of clear, scan, lookup and response.
   ght_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Slot store, scan logic and response register.
   ght_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

`default_nettype wire
